// ----- hw/rtl/box_filter_3x3_border_mean_defines.svh -----
// assertion macros for the box filter
`ifndef BOX_FILTER_3X3_BORDER_MEAN_DEFINES_SVH
`define BOX_FILTER_3X3_BORDER_MEAN_DEFINES_SVH

`ifndef ASSERT_OFF
`define BOX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define BOX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define BOX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BOX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/bfm_pkg.sv -----
package bfm_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int PIX_W        = 8;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int SUM_W       = PIX_W + 4;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int ROW_TOP = 0;
    localparam int ROW_MID = 1;
    localparam int ROW_BOT = 2;

    typedef enum logic
    {
        FE_IDLE,
        FE_READ
    } fe_state_t;

    // one image column of the window: rows r-2, r-1, r
    typedef logic [2:0][PIX_W-1:0] bfm_column_t;

    typedef struct packed
    {
        bfm_column_t       pixels;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              row_ge1;
        logic              row_ge2;
        logic              col_ge1;
        logic              col_ge2;
        logic              last_row;
        logic              last_col;
    } bfm_entry_t;

    // ceil(2^16 / count), exact floor for sums up to 9 * 255
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] val;
        case (cnt)
            4'd1:    val = RECIP_W'(65536);
            4'd2:    val = RECIP_W'(32768);
            4'd3:    val = RECIP_W'(21846);
            4'd4:    val = RECIP_W'(16384);
            4'd5:    val = RECIP_W'(13108);
            4'd6:    val = RECIP_W'(10923);
            4'd7:    val = RECIP_W'(9363);
            4'd8:    val = RECIP_W'(8192);
            4'd9:    val = RECIP_W'(7282);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- hw/rtl/bfm_front.sv -----
module bfm_front
    import bfm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIX_W-1:0]       pixel_value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   q_full,
    output logic                   q_push,
    output bfm_entry_t             q_entry
);

    fe_state_t          fe_state_reg;
    fe_state_t          fe_state_next;
    logic [ROW_W-1:0]   row_count_reg;
    logic [ROW_W-1:0]   row_count_next;
    logic [COL_W-1:0]   col_count_reg;
    logic [COL_W-1:0]   col_count_next;
    logic [COL_W-1:0]   last_col_reg;
    logic [COL_W-1:0]   last_col_next;
    logic [ROW_W-1:0]   last_row_reg;
    logic [ROW_W-1:0]   last_row_next;

    logic [PIX_W-1:0]   pix_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [2*PIX_W-1:0] rdata_reg;

    // word at column c: {row r-1, row r-2}
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

    logic                    accept;
    logic                    cfg_we;
    logic [WIDTH_CFG_W-1:0]  width_raw;
    logic [WIDTH_CFG_W-1:0]  width_m1;
    logic [HEIGHT_CFG_W-1:0] height_raw;
    logic [HEIGHT_CFG_W-1:0] height_m1;

    always_comb
    begin
        in_stall  = !((fe_state_reg == FE_IDLE) && !q_full);
        accept    = in_valid && !in_stall;
        cfg_ready = (fe_state_reg == FE_IDLE);
        cfg_we    = cfg_valid && cfg_ready;
        q_push    = 1'b0;

        fe_state_next  = fe_state_reg;
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        last_col_next  = last_col_reg;
        last_row_next  = last_row_reg;

        width_raw  = cfg_data[WIDTH_CFG_W-1:0];
        width_m1   = width_raw - WIDTH_CFG_W'(1);
        height_raw = cfg_data[HEIGHT_CFG_W-1:0];
        height_m1  = height_raw - HEIGHT_CFG_W'(1);

        case (fe_state_reg)
            FE_IDLE:
            begin
                if (accept)
                begin
                    fe_state_next = FE_READ;
                    if (col_count_reg == last_col_reg)
                    begin
                        col_count_next = '0;
                        if (row_count_reg == last_row_reg)
                        begin
                            row_count_next = '0;
                        end
                        else
                        begin
                            row_count_next = row_count_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        col_count_next = col_count_reg + COL_W'(1);
                    end
                end
            end
            FE_READ:
            begin
                q_push        = 1'b1;
                fe_state_next = FE_IDLE;
            end
            default:
            begin
                fe_state_next = FE_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    if (width_raw == '0)
                    begin
                        last_col_next = '0;
                    end
                    else if (width_raw > WIDTH_CFG_W'(MAX_WIDTH))
                    begin
                        last_col_next = COL_W'(MAX_WIDTH - 1);
                    end
                    else
                    begin
                        last_col_next = width_m1[COL_W-1:0];
                    end
                    row_count_next = '0;
                    col_count_next = '0;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    if (height_raw == '0)
                    begin
                        last_row_next = '0;
                    end
                    else if (height_raw > HEIGHT_CFG_W'(MAX_HEIGHT))
                    begin
                        last_row_next = ROW_W'(MAX_HEIGHT - 1);
                    end
                    else
                    begin
                        last_row_next = height_m1[ROW_W-1:0];
                    end
                    row_count_next = '0;
                    col_count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        q_entry.pixels[ROW_TOP] = rdata_reg[PIX_W-1:0];
        q_entry.pixels[ROW_MID] = rdata_reg[2*PIX_W-1:PIX_W];
        q_entry.pixels[ROW_BOT] = pix_reg;
        q_entry.row             = row_reg;
        q_entry.col             = col_reg;
        q_entry.row_ge1         = (row_reg != '0);
        q_entry.row_ge2         = (row_reg > ROW_W'(1));
        q_entry.col_ge1         = (col_reg != '0);
        q_entry.col_ge2         = (col_reg > COL_W'(1));
        q_entry.last_row        = (row_reg == last_row_reg);
        q_entry.last_col        = (col_reg == last_col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_state_reg  <= FE_IDLE;
            row_count_reg <= '0;
            col_count_reg <= '0;
            last_col_reg  <= COL_W'(MAX_WIDTH - 1);
            last_row_reg  <= ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            fe_state_reg  <= fe_state_next;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            last_col_reg  <= last_col_next;
            last_row_reg  <= last_row_next;
        end
    end

    // line memory: read on accept, write back in the next cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= line_mem[col_count_reg];
            pix_reg   <= pixel_value;
            row_reg   <= row_count_reg;
            col_reg   <= col_count_reg;
        end
        if (fe_state_reg == FE_READ)
        begin
            line_mem[col_reg] <= {pix_reg, rdata_reg[2*PIX_W-1:PIX_W]};
        end
    end

endmodule

// ----- hw/rtl/bfm_queue.sv -----
module bfm_queue
    import bfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bfm_entry_t push_entry,
    input  logic       pop,
    output bfm_entry_t pop_entry,
    output logic       full,
    output logic       empty
);

    bfm_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    always_comb
    begin
        full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
        empty     = (count_reg == '0);
        pop_entry = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;

        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hw/rtl/bfm_back.sv -----
module bfm_back
    import bfm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  bfm_entry_t       q_entry,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] smoothed_value,
    output logic [ROW_W-1:0] out_row,
    output logic [COL_W-1:0] out_col,
    output logic             last_of_run,
    frame_done
);

    // result kinds in emission order
    typedef enum logic [1:0]
    {
        RK_UP_LEFT,
        RK_UP_HERE,
        RK_LO_LEFT,
        RK_LO_HERE
    } result_kind_t;

    bfm_column_t        win_reg [3];
    bfm_entry_t         cur_reg;
    logic [3:0]         pend_reg;
    logic [3:0]         pend_next;
    logic               a_valid_reg;
    logic               a_valid_next;
    logic [SUM_W-1:0]   a_sum_reg;
    logic [RECIP_W-1:0] a_recip_reg;
    logic [ROW_W-1:0]   a_row_reg;
    logic [COL_W-1:0]   a_col_reg;
    logic               a_last_reg;
    logic               a_done_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PIX_W-1:0]   out_value_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic               out_last_reg;
    logic               out_done_reg;

    logic               out_free;
    logic               a_free;
    logic               issue;
    logic               a_move;
    result_kind_t       sel;
    logic [3:0]         sel_oh;
    logic [3:0]         pend_after;
    logic [3:0]         entry_mask;
    logic [2:0]         row_en;
    logic [2:0]         col_en;
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   cnt;
    logic [ROW_W-1:0]   ctr_row;
    logic [COL_W-1:0]   ctr_col;
    logic [PROD_W-1:0]  prod;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        a_free   = !a_valid_reg || out_free;
        a_move   = a_valid_reg && out_free;
        q_pop    = (pend_reg == '0) && !q_empty;
        issue    = a_free && (pend_reg != '0);

        entry_mask = {q_entry.last_row && q_entry.last_col,
                      q_entry.last_row && q_entry.col_ge1,
                      q_entry.row_ge1 && q_entry.last_col,
                      q_entry.row_ge1 && q_entry.col_ge1};

        if (pend_reg[0])
        begin
            sel = RK_UP_LEFT;
        end
        else if (pend_reg[1])
        begin
            sel = RK_UP_HERE;
        end
        else if (pend_reg[2])
        begin
            sel = RK_LO_LEFT;
        end
        else
        begin
            sel = RK_LO_HERE;
        end
        sel_oh     = 4'b0001 << sel;
        pend_after = pend_reg & ~sel_oh;

        row_en  = '0;
        col_en  = '0;
        ctr_row = cur_reg.row;
        ctr_col = cur_reg.col;
        row_en[ROW_BOT] = 1'b1;
        col_en[2]       = 1'b1;
        case (sel)
            RK_UP_LEFT:
            begin
                row_en[ROW_TOP] = cur_reg.row_ge2;
                row_en[ROW_MID] = 1'b1;
                col_en[0]       = cur_reg.col_ge2;
                col_en[1]       = 1'b1;
                ctr_row         = cur_reg.row - ROW_W'(1);
                ctr_col         = cur_reg.col - COL_W'(1);
            end
            RK_UP_HERE:
            begin
                row_en[ROW_TOP] = cur_reg.row_ge2;
                row_en[ROW_MID] = 1'b1;
                col_en[1]       = cur_reg.col_ge1;
                ctr_row         = cur_reg.row - ROW_W'(1);
            end
            RK_LO_LEFT:
            begin
                row_en[ROW_MID] = cur_reg.row_ge1;
                col_en[0]       = cur_reg.col_ge2;
                col_en[1]       = 1'b1;
                ctr_col         = cur_reg.col - COL_W'(1);
            end
            RK_LO_HERE:
            begin
                row_en[ROW_MID] = cur_reg.row_ge1;
                col_en[1]       = cur_reg.col_ge1;
            end
            default:
            begin
            end
        endcase

        sum = '0;
        cnt = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (col_en[i] && row_en[j])
                begin
                    sum = sum + SUM_W'(win_reg[i][j]);
                    cnt = cnt + CNT_W'(1);
                end
            end
        end

        prod = PROD_W'(a_sum_reg) * PROD_W'(a_recip_reg);

        pend_next = pend_reg;
        if (q_pop)
        begin
            pend_next = entry_mask;
        end
        else if (issue)
        begin
            pend_next = pend_after;
        end

        a_valid_next = a_valid_reg;
        if (issue)
        begin
            a_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            a_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (a_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= q_entry.pixels;
            cur_reg    <= q_entry;
        end
        if (issue)
        begin
            a_sum_reg   <= sum;
            a_recip_reg <= recip(cnt);
            a_row_reg   <= ctr_row;
            a_col_reg   <= ctr_col;
            a_last_reg  <= (pend_after == '0);
            a_done_reg  <= (sel == RK_LO_HERE);
        end
        if (a_move)
        begin
            out_value_reg <= prod[RECIP_SHIFT +: PIX_W];
            out_row_reg   <= a_row_reg;
            out_col_reg   <= a_col_reg;
            out_last_reg  <= a_last_reg;
            out_done_reg  <= a_done_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign smoothed_value = out_value_reg;
    assign out_row        = out_row_reg;
    assign out_col        = out_col_reg;
    assign last_of_run    = out_last_reg;
    assign frame_done     = out_done_reg;

endmodule

// ----- hw/rtl/box_filter_3x3_border_mean.sv -----
// 3x3 box filter over an 8-bit grayscale raster stream of up to 1024 x 4096 pixels. Each result
// is the floor of the mean of a pixel and its neighbors inside the image, tagged with its row,
// column, a last-of-run mark (final result caused by one input pixel) and an end-of-frame mark.
// A result leaves as soon as its neighborhood has arrived: none, one or two per pixel, up to four
// in the last row. The input side takes no new pixel until the line memory read-modify-write of
// the last one is done (read on accept, write back in the next cycle). The output side first loads
// each pixel's column into the window, then issues one result per cycle while the output is not
// stalled; a 2-deep queue between the two sides absorbs the difference. A result passes the input
// registers, a queue slot, the window, the sum register and the output register. Writing either
// image_width (index 0) or image_height (index 1) restarts the frame; out-of-range sizes clamp to
// 1 and the maximum. No clearing pass after reset: the line memory is only used where written.
`include "box_filter_3x3_border_mean_defines.svh"

module box_filter_3x3_border_mean
    import bfm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIX_W-1:0]       pixel_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PIX_W-1:0]       smoothed_value,
    output logic [ROW_W-1:0]       out_row,
    output logic [COL_W-1:0]       out_col,
    output logic                   last_of_run,
    output logic                   frame_done,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    bfm_entry_t push_entry;
    bfm_entry_t pop_entry;

    bfm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    bfm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    bfm_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_entry        (pop_entry),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .smoothed_value (smoothed_value),
        .out_row        (out_row),
        .out_col        (out_col),
        .last_of_run    (last_of_run),
        .frame_done     (frame_done)
    );

    // every accepted transaction reaches the queue in the next cycle
    `BOX_ASSERT_NEXT(a_accept_then_push, clk, rst_n, in_valid && !in_stall, q_push)
    `BOX_ASSERT_IMPL(a_push_has_room, clk, rst_n, q_push, !q_full)
    `BOX_ASSERT_IMPL(a_pop_has_entry, clk, rst_n, q_pop, !q_empty)

endmodule
